@@ sv/btc_pkg.sv @@
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and codes for the button tap and hold classifier.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int unsigned NumButtons = 4;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_PRESSED  = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_HELD     = 3'd2,
    KIND_SINGLE   = 3'd3,
    KIND_DOUBLE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_DOUBLE_TAP_ENABLE = 2'd0,
    REG_HOLD_ENABLE       = 2'd1,
    REG_WINDOW_TICKS      = 2'd2,
    REG_NONE              = 2'd3
  } reg_e;

  localparam logic [7:0]  OneTap       = 8'h01;
  localparam logic [7:0]  CountMax     = 8'hff;
  localparam logic [15:0] WindowReset  = 16'd250;

  // Results caused by one input item: one slot per button.
  typedef struct packed {
    logic  [NumButtons-1:0] mask;
    kind_e [NumButtons-1:0] kind;
    logic  [NumButtons-1:0][1:0] btn;
  } bundle_t;

endpackage

@@ sv/button_tap_hold_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button_tap_hold_classifier_unit
// Classifies four buttons into pressed, released, held, single and double tap.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle whenever its two-entry result queue has a
// free entry. A press or release gives one result beat; a tick gives one beat
// per expiring button with an event, in button index order; a tick with several
// beats holds the output side while the next input is taken into the second
// queue entry. All per-button state is updated in the cycle the input beat is
// accepted; its results enter the head entry, or the second one while the head
// holds beats. Buttons are indexed right_hand * 2 + upper_button.
module button_tap_hold_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [1:0] op, [2] right_hand, [3] upper_button
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] event_right_hand, [1] event_upper_button,
                                  // [4:2] event_kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int unsigned NB = btc_pkg::NumButtons;

  logic        double_tap_enable;
  logic        hold_enable;
  logic [15:0] window_ticks;

  logic [15:0] timer_remaining      [NB];
  logic        timer_running        [NB];
  logic [7:0]  press_count          [NB];
  logic        last_was_press       [NB];
  logic        skip_next_release    [NB];

  logic [15:0] timer_remaining_next   [NB];
  logic        timer_running_next     [NB];
  logic [7:0]  press_count_next       [NB];
  logic        last_was_press_next    [NB];
  logic        skip_next_release_next [NB];

  btc_pkg::bundle_t head, head_next, tail, tail_next, bundle_new;

  btc_pkg::op_e     in_op;
  logic [1:0]       in_idx;
  logic             in_acc;
  logic             active;
  logic [15:0]      window_eff;
  logic [1:0]       out_sel;
  logic [NB-1:0]    head_left;

  assign in_op      = btc_pkg::op_e'(s_tdata[1:0]);
  assign in_idx     = {s_tdata[2], s_tdata[3]};
  assign s_tready   = ~(|tail.mask);
  assign in_acc     = s_tvalid & s_tready;
  assign active     = double_tap_enable | hold_enable;
  assign window_eff = (window_ticks == 16'd0) ? 16'd1 : window_ticks;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_tap_enable <= 1'b1;
      hold_enable       <= 1'b1;
      window_ticks      <= btc_pkg::WindowReset;
    end else if (cfg_valid) begin
      unique case (btc_pkg::reg_e'(cfg_addr))
        btc_pkg::REG_DOUBLE_TAP_ENABLE: double_tap_enable <= cfg_data[0];
        btc_pkg::REG_HOLD_ENABLE:       hold_enable       <= cfg_data[0];
        btc_pkg::REG_WINDOW_TICKS:      window_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bundle_new = '0;
    for (int i = 0; i < NB; i++) begin
      timer_remaining_next[i]   = timer_remaining[i];
      timer_running_next[i]     = timer_running[i];
      press_count_next[i]       = press_count[i];
      last_was_press_next[i]    = last_was_press[i];
      skip_next_release_next[i] = skip_next_release[i];
    end
    unique case (in_op)
      btc_pkg::OP_PRESS: begin
        bundle_new.mask[0] = 1'b1;
        bundle_new.kind[0] = btc_pkg::KIND_PRESSED;
        bundle_new.btn[0]  = in_idx;
        if (active) begin
          last_was_press_next[in_idx] = 1'b1;
          if (!timer_running[in_idx]) begin
            timer_remaining_next[in_idx] = window_eff;
            timer_running_next[in_idx]   = 1'b1;
          end
        end
      end
      btc_pkg::OP_RELEASE: begin
        bundle_new.mask[0] = 1'b1;
        bundle_new.kind[0] = btc_pkg::KIND_RELEASED;
        bundle_new.btn[0]  = in_idx;
        if (active) begin
          last_was_press_next[in_idx] = 1'b0;
          if (skip_next_release[in_idx]) begin
            skip_next_release_next[in_idx] = 1'b0;
          end else if (press_count[in_idx] != btc_pkg::CountMax) begin
            press_count_next[in_idx] = press_count[in_idx] + 8'd1;
          end
        end
      end
      btc_pkg::OP_TICK: begin
        for (int i = 0; i < NB; i++) begin
          bundle_new.btn[i]  = 2'(i);
          bundle_new.kind[i] = btc_pkg::KIND_HELD;
          if (timer_running[i]) begin
            if (timer_remaining[i] > 16'd1) begin
              timer_remaining_next[i] = timer_remaining[i] - 16'd1;
            end else begin
              timer_remaining_next[i] = 16'd0;
              timer_running_next[i]   = 1'b0;
              press_count_next[i]     = 8'd0;
              if (last_was_press[i]) skip_next_release_next[i] = 1'b1;
              if (hold_enable && press_count[i] == 8'd0) begin
                bundle_new.mask[i] = 1'b1;
              end
              if (double_tap_enable) begin
                if (press_count[i] == btc_pkg::OneTap) begin
                  bundle_new.mask[i] = 1'b1;
                  bundle_new.kind[i] = btc_pkg::KIND_SINGLE;
                end else if (press_count[i] > btc_pkg::OneTap) begin
                  bundle_new.mask[i] = 1'b1;
                  bundle_new.kind[i] = btc_pkg::KIND_DOUBLE;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        timer_remaining[i]   <= 16'd0;
        timer_running[i]     <= 1'b0;
        press_count[i]       <= 8'd0;
        last_was_press[i]    <= 1'b0;
        skip_next_release[i] <= 1'b0;
      end
    end else if (in_acc) begin
      for (int i = 0; i < NB; i++) begin
        timer_remaining[i]   <= timer_remaining_next[i];
        timer_running[i]     <= timer_running_next[i];
        press_count[i]       <= press_count_next[i];
        last_was_press[i]    <= last_was_press_next[i];
        skip_next_release[i] <= skip_next_release_next[i];
      end
    end
  end

  always_comb begin
    priority if (head.mask[0]) out_sel = 2'd0;
    else if (head.mask[1])     out_sel = 2'd1;
    else if (head.mask[2])     out_sel = 2'd2;
    else                       out_sel = 2'd3;
  end

  always_comb begin
    head_left = head.mask;
    if (m_tready) head_left[out_sel] = 1'b0;
  end

  assign m_tvalid = |head.mask;
  assign m_tdata  = {3'b000, head.kind[out_sel], head.btn[out_sel][0], head.btn[out_sel][1]};
  assign m_tlast  = (head.mask & (head.mask - 4'd1)) == 4'd0;

  always_comb begin
    head_next      = head;
    head_next.mask = head_left;
    tail_next      = tail;
    if (head_left == '0) begin
      if (|tail.mask) begin
        head_next = tail;
        tail_next.mask = '0;
      end else if (in_acc) begin
        head_next = bundle_new;
      end
    end else if (in_acc) begin
      tail_next = bundle_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.mask <= '0;
      tail.mask <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

endmodule

@@ sv/btc_checker.sv @@
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks for the button tap and hold classifier.
// ----------------------------------------------------------------------------
module btc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_echo_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:2] == btc_pkg::KIND_PRESSED ||
                 m_tdata[4:2] == btc_pkg::KIND_RELEASED) |-> m_tlast)
    else $error("press or release echo is not the final beat of its item");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:2] <= btc_pkg::KIND_DOUBLE && m_tdata[7:5] == 3'b000)
    else $error("bad output kind or padding");

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_tready && !m_tvalid)
    else $error("queue not empty after reset");

endmodule

bind button_tap_hold_classifier_unit btc_checker u_btc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/button_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_checker
// Watches the input, result and register channels of the button tap and hold
// classifier. It keeps its own copy of the per-button timers, tap counts and
// register settings, and works out the event beats that each accepted input
// beat must cause. Each result beat is compared with the oldest expected beat.
// ----------------------------------------------------------------------------
module button_event_checker
  import btc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          events_awaited
);

  typedef struct packed {
    logic  right;
    logic  upper;
    kind_e kind;
    logic  last;
  } event_t;

  event_t expected_events[$];

  logic        dt_en;
  logic        hold_en;
  logic [15:0] window;

  logic [15:0] remaining    [NumButtons];
  logic        running      [NumButtons];
  logic [7:0]  taps         [NumButtons];
  logic        pressed_last [NumButtons];
  logic        skip_release [NumButtons];

  int errs = 0;

  function automatic event_t beat_of(input logic [1:0] btn, input kind_e k);
    event_t e;
    e.right = btn[1];
    e.upper = btn[0];
    e.kind  = k;
    e.last  = 1'b0;
    return e;
  endfunction

  task automatic classify_item(input logic [7:0] beat);
    op_e        op;
    logic [1:0] idx;
    logic       active;
    logic       fire;
    kind_e      k;
    event_t     produced[$];
    op     = op_e'(beat[1:0]);
    idx    = {beat[2], beat[3]};
    active = dt_en | hold_en;
    case (op)
      OP_PRESS: begin
        produced.push_back(beat_of(idx, KIND_PRESSED));
        if (active) begin
          pressed_last[idx] = 1'b1;
          if (!running[idx]) begin
            remaining[idx] = (window == 16'd0) ? 16'd1 : window;
            running[idx]   = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        produced.push_back(beat_of(idx, KIND_RELEASED));
        if (active) begin
          pressed_last[idx] = 1'b0;
          if (skip_release[idx]) begin
            skip_release[idx] = 1'b0;
          end else if (taps[idx] != CountMax) begin
            taps[idx] = taps[idx] + 8'd1;
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NumButtons; i++) begin
          if (running[i]) begin
            if (remaining[i] > 16'd1) begin
              remaining[i] = remaining[i] - 16'd1;
            end else begin
              remaining[i] = 16'd0;
              if (pressed_last[i]) skip_release[i] = 1'b1;
              fire = 1'b0;
              k    = KIND_PRESSED;
              if (hold_en && taps[i] == 8'd0) begin
                k    = KIND_HELD;
                fire = 1'b1;
              end
              if (dt_en) begin
                if (taps[i] == OneTap) begin
                  k    = KIND_SINGLE;
                  fire = 1'b1;
                end else if (taps[i] > OneTap) begin
                  k    = KIND_DOUBLE;
                  fire = 1'b1;
                end
              end
              running[i] = 1'b0;
              taps[i]    = 8'd0;
              if (fire) produced.push_back(beat_of(i[1:0], k));
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
    foreach (produced[j]) expected_events.push_back(produced[j]);
  endtask

  task automatic report(input string what, input event_t want);
    errs++;
    if (errs <= 10)
      $display("%0t %s: expected right=%0d upper=%0d kind=%0d last=%0d, got tdata=%02h tlast=%0d",
               $time, what, want.right, want.upper, want.kind, want.last, m_tdata, m_tlast);
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      dt_en   = 1'b1;
      hold_en = 1'b1;
      window  = WindowReset;
      for (int i = 0; i < NumButtons; i++) begin
        remaining[i]    = 16'd0;
        running[i]      = 1'b0;
        taps[i]         = 8'd0;
        pressed_last[i] = 1'b0;
        skip_release[i] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          report("unexpected beat", '0);
        end else begin
          want = expected_events.pop_front();
          if (m_tdata[0] !== want.right || m_tdata[1] !== want.upper ||
              m_tdata[4:2] !== want.kind || m_tdata[7:5] !== 3'b000 ||
              m_tlast !== want.last)
            report("wrong beat", want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_e'(cfg_addr))
          REG_DOUBLE_TAP_ENABLE: dt_en   = cfg_data[0];
          REG_HOLD_ENABLE:       hold_en = cfg_data[0];
          REG_WINDOW_TICKS:      window  = cfg_data;
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) classify_item(s_tdata);
    end
    events_awaited <= expected_events.size();
    mismatch_count <= errs;
  end

endmodule

@@ tb/button_tap_hold_classifier_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_tap_hold_classifier_unit_tb
// Drives press, release, tick and reserved beats into the classifier under a
// range of register settings: directed cases for held, single and double tap,
// skipped releases, several expiries on one tick and the shortest windows,
// then random tap gestures with random idling on both streams.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module button_tap_hold_classifier_unit_tb;
  import btc_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr  = 2'b00;
  logic [15:0] cfg_data  = 16'h0000;

  int   mismatch_count;
  int   events_awaited;
  int   tx_idle_pct    = 25;
  int   rx_idle_pct    = 25;
  int   hold_left      = 0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  always #2 clk = ~clk;

  button_tap_hold_classifier_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  button_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .events_awaited (events_awaited)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      m_tready       <= 1'b0;
      hold_left      <= 150;
      long_hold_done <= 1'b1;
    end else if (rx_idle_pct > 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
      m_tready  <= 1'b0;
      hold_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_item(input op_e op, input logic [1:0] btn);
    if (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, btn[0], btn[1], op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_item(OP_TICK, 2'($urandom));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (events_awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e addr, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int         done;
    int         r;
    int         taps;
    logic [1:0] btn;
    done = 0;
    while (done < n_items) begin
      r   = $urandom_range(0, 9);
      btn = 2'($urandom_range(0, 3));
      if (r < 6) begin
        // A gesture on one button: some taps, sometimes left held down.
        taps = $urandom_range(0, 3);
        push_item(OP_PRESS, btn);
        done++;
        repeat (taps) begin
          push_item(OP_RELEASE, btn);
          push_item(OP_PRESS, btn);
          done += 2;
        end
        if ($urandom_range(0, 1)) begin
          push_item(OP_RELEASE, btn);
          done++;
        end
      end else if (r < 9) begin
        push_item(OP_TICK, 2'($urandom));
        done++;
      end else begin
        push_item(op_e'($urandom_range(0, 3)), 2'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset enables with a short window: a lone press is reported held, and
    // the release that follows a hold is not counted.
    write_reg(REG_WINDOW_TICKS, 16'd3);
    push_item(OP_PRESS, 2'd0);
    tick_run(3);
    push_item(OP_RELEASE, 2'd0);
    push_item(OP_TICK, 2'd1);
    push_item(OP_RSVD, 2'd3);
    push_item(OP_RSVD, 2'd0);
    settle();
    push_item(OP_PRESS, 2'd0);
    push_item(OP_RELEASE, 2'd0);
    tick_run(3);
    push_item(OP_PRESS, 2'd1);
    push_item(OP_RELEASE, 2'd1);
    push_item(OP_PRESS, 2'd1);
    push_item(OP_RELEASE, 2'd1);
    tick_run(3);

    // All four buttons expire on the same tick.
    push_item(OP_PRESS, 2'd3);
    push_item(OP_PRESS, 2'd2);
    push_item(OP_RELEASE, 2'd2);
    push_item(OP_PRESS, 2'd1);
    push_item(OP_RELEASE, 2'd1);
    push_item(OP_PRESS, 2'd1);
    push_item(OP_RELEASE, 2'd1);
    push_item(OP_PRESS, 2'd0);
    tick_run(3);

    // A second press while the window runs does not restart it.
    push_item(OP_PRESS, 2'd2);
    tick_run(1);
    push_item(OP_PRESS, 2'd2);
    tick_run(2);
    push_item(OP_RELEASE, 2'd2);
    settle();
    write_reg(REG_WINDOW_TICKS, 16'd0);
    push_item(OP_PRESS, 2'd1);
    tick_run(1);
    push_item(OP_RELEASE, 2'd1);

    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'hfffe);
    write_reg(REG_WINDOW_TICKS, 16'd2);
    push_item(OP_PRESS, 2'd0);
    push_item(OP_RELEASE, 2'd0);
    tick_run(2);
    push_item(OP_PRESS, 2'd1);
    tick_run(2);
    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'd1);
    write_reg(REG_HOLD_ENABLE, 16'd0);
    push_item(OP_PRESS, 2'd2);
    tick_run(2);
    push_item(OP_PRESS, 2'd3);
    push_item(OP_RELEASE, 2'd3);
    tick_run(2);
    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'd0);
    push_item(OP_PRESS, 2'd3);
    push_item(OP_RELEASE, 2'd3);
    tick_run(2);

    // A window started while enabled still runs out after both features are
    // switched off, so the next press starts a fresh window.
    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'd1);
    write_reg(REG_HOLD_ENABLE, 16'hffff);
    write_reg(REG_WINDOW_TICKS, 16'd4);
    push_item(OP_PRESS, 2'd2);
    push_item(OP_RELEASE, 2'd2);
    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'd0);
    write_reg(REG_HOLD_ENABLE, 16'd0);
    tick_run(4);
    settle();
    write_reg(REG_DOUBLE_TAP_ENABLE, 16'd1);
    write_reg(REG_HOLD_ENABLE, 16'd1);
    push_item(OP_PRESS, 2'd2);
    tick_run(4);

    // Results back up behind a long receiver stall while beats keep coming.
    settle();
    write_reg(REG_NONE, 16'hffff);
    tx_idle_pct = 0;
    write_reg(REG_WINDOW_TICKS, 16'd5);
    long_hold_req <= 1'b1;
    repeat (30) push_item(op_e'($urandom_range(0, 1)), 2'($urandom));
    settle();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DOUBLE_TAP_ENABLE, (p == 2) ? 16'd0 : 16'd1);
      write_reg(REG_HOLD_ENABLE, (p == 1) ? 16'd0 : 16'd1);
      write_reg(REG_WINDOW_TICKS, (p == 3) ? 16'd1 : 16'($urandom_range(1, 4)));
      tx_idle_pct = (p == 3) ? 0 : 10 + 15 * p;
      rx_idle_pct <= (p == 3) ? 0 : 40 - 10 * p;
      random_phase(13);
      settle();
    end

    if (mismatch_count == 0 && events_awaited == 0) begin
      $display("[button_tap_hold_classifier_unit] OK");
    end else begin
      $display("[button_tap_hold_classifier_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[button_tap_hold_classifier_unit] ERROR");
    $finish;
  end

endmodule
